>>> sv/bresenham_line_rasterizer_macros.svh
// ---------------------------------------------------------------------------
// Bresenham line rasterizer assertion macros
// Shared property shorthands for the checker, clocked on clk and
// disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BLR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line rasterizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define BLR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line rasterizer check failed");

`endif

>>> sv/blr_pkg.sv
// ---------------------------------------------------------------------------
// Bresenham line rasterizer package
// Widths, request and move codes, and small helpers shared by the block.
// ---------------------------------------------------------------------------
package blr_pkg;

    // Coordinate width and the widths that follow from it.
    localparam int COORD_BITS = 16;
    localparam int STEP_W     = COORD_BITS + 1;  // major axis length
    localparam int SINC_W     = COORD_BITS + 2;  // 2*minor
    localparam int ERR_W      = COORD_BITS + 3;  // error term and diagonal increment

    typedef logic [COORD_BITS-1:0] coord_t;

    // Request codes.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    // Unit move per axis: bit 0 = axis moves, bit 1 = axis goes down.
    typedef logic [1:0] axis_move_t;
    localparam axis_move_t MV_NONE = 2'b00;
    localparam axis_move_t MV_UP   = 2'b01;
    localparam axis_move_t MV_DOWN = 2'b11;

    // Two-axis move: x in bits 1:0, y in bits 3:2.
    typedef logic [3:0] move_t;

    // Coordinate delta of one axis move.
    function automatic coord_t axis_delta(axis_move_t code);
        coord_t d;
        unique case (code)
            MV_UP:   d = coord_t'(1);
            MV_DOWN: d = '1;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

>>> sv/bresenham_line_rasterizer.sv
// ---------------------------------------------------------------------------
// Bresenham line rasterizer
// Integer line drawing for all eight octants: a start request loads two
// endpoints and emits the first pixel, each step request emits the next one.
// ---------------------------------------------------------------------------
//  Channel | Valid     | Stall     | Payload
//  --------+-----------+-----------+-------------------------------------------
//  request | req_valid | req_stall | req_type, x_start, y_start, x_end, y_end
//  pixel   | pix_valid | pix_stall | pixel_x, pixel_y, last
//
//  One request per clock is taken unless stalled; a pixel passes the request
//  and result registers. The loop that sets the rate is the error term update
//  (one add and a sign test). A step request with no active line is consumed
//  and gives no pixel. Reset clears the line state, so no line is active
//  after reset. A stalled pixel holds the result register; the request
//  register then fills and req_stall rises while both stay occupied.
// ---------------------------------------------------------------------------
module bresenham_line_rasterizer
    import blr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          req_type,
    input  logic signed [COORD_BITS-1:0]  x_start,
    input  logic signed [COORD_BITS-1:0]  y_start,
    input  logic signed [COORD_BITS-1:0]  x_end,
    input  logic signed [COORD_BITS-1:0]  y_end,
    output logic                          pix_valid,
    input  logic                          pix_stall,
    output logic signed [COORD_BITS-1:0]  pixel_x,
    output logic signed [COORD_BITS-1:0]  pixel_y,
    output logic                          last
);

    // Request register.
    logic         in_valid_reg;
    logic         in_type_reg;
    coord_t       in_x0_reg, in_y0_reg, in_x1_reg, in_y1_reg;

    // Line state.
    coord_t             cur_x_reg, cur_x_next;
    coord_t             cur_y_reg, cur_y_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    move_t              smove_reg, smove_next;
    move_t              dmove_reg, dmove_next;
    logic [SINC_W-1:0]  sinc_reg, sinc_next;
    logic [ERR_W-1:0]   dinc_reg, dinc_next;
    logic               active_reg, active_next;

    // Result register.
    logic         out_valid_reg, out_valid_next;
    coord_t       out_x_reg, out_y_reg;
    logic         out_last_reg;

    logic         advance;
    logic         req_accept;

    // Start request terms.
    logic [STEP_W-1:0]  dx, dy, ax, ay, major, minor;
    axis_move_t         xcode, ycode;

    // The result register may load when it is empty or being taken.
    assign advance    = !out_valid_reg || !pix_stall;
    assign req_stall  = in_valid_reg && !advance;
    assign req_accept = req_valid && !req_stall;

    // Endpoint differences, magnitudes and unit moves.
    always_comb
    begin
        dx    = {in_x1_reg[COORD_BITS-1], in_x1_reg} - {in_x0_reg[COORD_BITS-1], in_x0_reg};
        dy    = {in_y1_reg[COORD_BITS-1], in_y1_reg} - {in_y0_reg[COORD_BITS-1], in_y0_reg};
        ax    = dx[STEP_W-1] ? (~dx + STEP_W'(1)) : dx;
        ay    = dy[STEP_W-1] ? (~dy + STEP_W'(1)) : dy;
        xcode = dx[STEP_W-1] ? MV_DOWN : MV_UP;
        ycode = dy[STEP_W-1] ? MV_DOWN : MV_UP;
        if (ax >= ay)
        begin
            major = ax;
            minor = ay;
        end
        else
        begin
            major = ay;
            minor = ax;
        end
    end

    // Next line state and result.
    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        err_next       = err_reg;
        steps_next     = steps_reg;
        smove_next     = smove_reg;
        dmove_next     = dmove_reg;
        sinc_next      = sinc_reg;
        dinc_next      = dinc_reg;
        active_next    = active_reg;
        out_valid_next = 1'b0;
        if (in_valid_reg)
        begin
            if (in_type_reg == REQ_START)
            begin
                cur_x_next     = in_x0_reg;
                cur_y_next     = in_y0_reg;
                smove_next     = (ax >= ay) ? {MV_NONE, xcode} : {ycode, MV_NONE};
                dmove_next     = {ycode, xcode};
                sinc_next      = {minor, 1'b0};
                dinc_next      = {1'b0, minor, 1'b0} - {1'b0, major, 1'b0};
                err_next       = {1'b0, minor, 1'b0} - {2'b00, major};
                steps_next     = major;
                active_next    = (major != '0);
                out_valid_next = 1'b1;
            end
            else if (active_reg)
            begin
                if (err_reg[ERR_W-1])
                begin
                    cur_x_next = cur_x_reg + axis_delta(smove_reg[1:0]);
                    cur_y_next = cur_y_reg + axis_delta(smove_reg[3:2]);
                    err_next   = err_reg + {1'b0, sinc_reg};
                end
                else
                begin
                    cur_x_next = cur_x_reg + axis_delta(dmove_reg[1:0]);
                    cur_y_next = cur_y_reg + axis_delta(dmove_reg[3:2]);
                    err_next   = err_reg + dinc_reg;
                end
                steps_next     = steps_reg - STEP_W'(1);
                active_next    = (steps_reg != STEP_W'(1));
                out_valid_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            steps_reg     <= '0;
            smove_reg     <= '0;
            dmove_reg     <= '0;
            sinc_reg      <= '0;
            dinc_reg      <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (req_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= out_valid_next;
                cur_x_reg     <= cur_x_next;
                cur_y_reg     <= cur_y_next;
                err_reg       <= err_next;
                steps_reg     <= steps_next;
                smove_reg     <= smove_next;
                dmove_reg     <= dmove_next;
                sinc_reg      <= sinc_next;
                dinc_reg      <= dinc_next;
                active_reg    <= active_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            in_type_reg <= req_type;
            in_x0_reg   <= x_start;
            in_y0_reg   <= y_start;
            in_x1_reg   <= x_end;
            in_y1_reg   <= y_end;
        end
        if (advance)
        begin
            out_x_reg    <= cur_x_next;
            out_y_reg    <= cur_y_next;
            out_last_reg <= !active_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pixel_x   = out_x_reg;
    assign pixel_y   = out_y_reg;
    assign last      = out_last_reg;

endmodule

>>> sv/blr_checker.sv
// ---------------------------------------------------------------------------
// Bresenham line rasterizer checker
// Port-level properties of the rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
`include "bresenham_line_rasterizer_macros.svh"

module blr_checker
    import blr_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic                          req_stall,
    input  logic                          req_type,
    input  logic signed [COORD_BITS-1:0]  x_start,
    input  logic signed [COORD_BITS-1:0]  y_start,
    input  logic signed [COORD_BITS-1:0]  x_end,
    input  logic signed [COORD_BITS-1:0]  y_end,
    input  logic                          pix_valid,
    input  logic                          pix_stall,
    input  logic signed [COORD_BITS-1:0]  pixel_x,
    input  logic signed [COORD_BITS-1:0]  pixel_y,
    input  logic                          last
);

    // A stalled pixel stays put.
    `BLR_ASSERT_NEXT(a_pix_hold, pix_valid && pix_stall, pix_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(last))

    // Requests are held back only while a finished pixel waits.
    `BLR_ASSERT_SAME(a_stall_cause, req_stall, pix_valid && pix_stall)

    // A start request always yields a pixel once the result register is free.
    `BLR_ASSERT_NEXT(a_start_pixel, $past(req_valid && !req_stall && req_type == REQ_START) && !(pix_valid && pix_stall), pix_valid)

    // A line with equal endpoints is a single final pixel at the start point.
    `BLR_ASSERT_NEXT(a_point_line, $past(req_valid && !req_stall && req_type == REQ_START && x_start == x_end && y_start == y_end) && !(pix_valid && pix_stall), pix_valid && last && pixel_x == $past(x_start, 2) && pixel_y == $past(y_start, 2))

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (.*);

>>> test/bresenham_line_rasterizer_tb.sv
// ---------------------------------------------------------------------------
// Bresenham line rasterizer testbench
// Drives start and step items into the rasterizer and keeps a cycle-free
// model of the line walk. Every pixel that leaves the block is compared,
// coordinate by coordinate and with its end flag, against the oldest
// predicted pixel. Directed lines come first, then random lines of mostly
// short length, with bursty requests and a stalling pixel consumer.
// ---------------------------------------------------------------------------
module bresenham_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import blr_pkg::*;

    localparam int MAX_COORD    = 2 ** (COORD_BITS - 1) - 1;
    localparam int MIN_COORD    = -(2 ** (COORD_BITS - 1));
    localparam int RANDOM_ITEMS = 1350;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PRINT_CAP    = 30;

    typedef logic signed [COORD_BITS-1:0] scoord_t;

    typedef struct packed {
        scoord_t x;
        scoord_t y;
        logic    end_flag;
    } pixel_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    // Block ports.
    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    req_valid = 1'b0;
    logic    req_stall;
    logic    req_type  = REQ_STEP;
    scoord_t x_start   = '0;
    scoord_t y_start   = '0;
    scoord_t x_end     = '0;
    scoord_t y_end     = '0;
    logic    pix_valid;
    logic    pix_stall = 1'b0;
    scoord_t pixel_x;
    scoord_t pixel_y;
    logic    last;

    // Line walk state of the prediction.
    scoord_t pen_x;
    scoord_t pen_y;
    int      decision;
    int      pixels_to_go;
    move_t   axial_move;
    move_t   slant_move;
    int      axial_gain;
    int      slant_gain;
    bit      drawing;

    pixel_t      pending_pixels[$];
    int          pixels_predicted = 0;
    int          mismatches       = 0;
    int          cycles           = 0;
    int          burst_left       = 0;
    int          stall_left       = 0;
    stall_mode_t stall_mode       = STALL_NONE;

    bresenham_line_rasterizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .last      (last)
    );

    always #1 clk = ~clk;

    // Timeout guard.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycles, pending_pixels.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // Unit offset of one axis move.
    function automatic int axis_step(input axis_move_t m);
        case (m)
            MV_UP:   return 1;
            MV_DOWN: return -1;
            default: return 0;
        endcase
    endfunction

    // Advance the predicted line by one item; a step with no line gives nothing.
    task automatic rasterize_item(input logic rtype, input scoord_t xs, input scoord_t ys,
                                  input scoord_t xe, input scoord_t ye,
                                  output bit produced, output pixel_t px);
        int         dx;
        int         dy;
        int         ax;
        int         ay;
        int         major;
        int         minor;
        axis_move_t xdir;
        axis_move_t ydir;
        move_t      mv;
        produced = 1'b0;
        px       = '0;
        if (rtype == REQ_START)
        begin
            dx    = int'(xe) - int'(xs);
            dy    = int'(ye) - int'(ys);
            ax    = (dx < 0) ? -dx : dx;
            ay    = (dy < 0) ? -dy : dy;
            xdir  = (dx < 0) ? MV_DOWN : MV_UP;
            ydir  = (dy < 0) ? MV_DOWN : MV_UP;
            if (ax >= ay)
            begin
                major      = ax;
                minor      = ay;
                axial_move = {MV_NONE, xdir};
            end
            else
            begin
                major      = ay;
                minor      = ax;
                axial_move = {ydir, MV_NONE};
            end
            slant_move   = {ydir, xdir};
            axial_gain   = 2 * minor;
            slant_gain   = 2 * (minor - major);
            decision     = 2 * minor - major;
            pixels_to_go = major;
            pen_x        = xs;
            pen_y        = ys;
            drawing      = (major != 0);
            produced     = 1'b1;
        end
        else if (drawing)
        begin
            // Negative error keeps to the major axis, otherwise step diagonally.
            if (decision < 0)
            begin
                mv        = axial_move;
                decision += axial_gain;
            end
            else
            begin
                mv        = slant_move;
                decision += slant_gain;
            end
            pen_x        = pen_x + COORD_BITS'(axis_step(mv[1:0]));
            pen_y        = pen_y + COORD_BITS'(axis_step(mv[3:2]));
            pixels_to_go = pixels_to_go - 1;
            drawing      = (pixels_to_go != 0);
            produced     = 1'b1;
        end
        if (produced)
            px = '{pen_x, pen_y, !drawing};
    endtask

    // Present one item, hold it until taken, then predict its pixel.
    task automatic send_item(input logic rtype, input scoord_t xs, input scoord_t ys,
                             input scoord_t xe, input scoord_t ye);
        bit     produced;
        pixel_t px;
        if (burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        req_valid <= 1'b1;
        req_type  <= rtype;
        x_start   <= xs;
        y_start   <= ys;
        x_end     <= xe;
        y_end     <= ye;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        burst_left--;
        rasterize_item(rtype, xs, ys, xe, ye, produced, px);
        if (produced)
        begin
            pending_pixels = {pending_pixels, px};
            pixels_predicted++;
        end
    endtask

    // Step item whose coordinate fields carry junk.
    task automatic send_step();
        send_item(REQ_STEP, scoord_t'($urandom), scoord_t'($urandom),
                  scoord_t'($urandom), scoord_t'($urandom));
    endtask

    // Pixel consumer stalls in one of four modes, picked anew when the current one runs out.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     pix_stall <= 1'b0;
            STALL_LIGHT:    pix_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    pix_stall <= ($urandom_range(0, 99) < 65);
            STALL_PERIODIC: pix_stall <= ((cycles % 5) < 2);
            default:        pix_stall <= 1'b0;
        endcase
    end

    // Compare every accepted pixel with the oldest prediction.
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (pending_pixels.size() == 0)
                report($sformatf("unexpected pixel (%0d,%0d) last=%0b",
                                 pixel_x, pixel_y, last));
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_x !== want.x)
                    report($sformatf("pixel_x %0d, predicted %0d", pixel_x, want.x));
                if (pixel_y !== want.y)
                    report($sformatf("pixel_y %0d, predicted %0d", pixel_y, want.y));
                if (last !== want.end_flag)
                    report($sformatf("last %0b, predicted %0b at (%0d,%0d)",
                                     last, want.end_flag, want.x, want.y));
            end
        end
    end

    // A step before any line has started is swallowed.
    task automatic test_idle_step();
        send_item(REQ_STEP, '1, '0, '1, '0);
    endtask

    // Equal endpoints give one flagged pixel; a following step gives nothing.
    task automatic test_degenerate();
        send_item(REQ_START, 16'sd5, -16'sd7, 16'sd5, -16'sd7);
        send_item(REQ_STEP, '0, '1, '0, '1);
    endtask

    // Short lines: x major, y major going down, an exact diagonal, a vertical.
    task automatic test_octants();
        send_item(REQ_START, 16'sd0, 16'sd0, 16'sd3, 16'sd1);
        repeat (3) send_step();
        send_item(REQ_START, 16'sd10, -16'sd4, 16'sd9, -16'sd7);
        repeat (3) send_step();
        send_item(REQ_START, -16'sd5, 16'sd5, -16'sd2, 16'sd2);
        repeat (3) send_step();
        send_item(REQ_START, 16'sd100, 16'sd0, 16'sd100, -16'sd2);
        repeat (2) send_step();
    endtask

    // Corner coordinates, a restart in mid-line, and a step past the end.
    task automatic test_extremes();
        send_item(REQ_START, scoord_t'(MIN_COORD), scoord_t'(MIN_COORD),
                  scoord_t'(MAX_COORD), scoord_t'(MAX_COORD));
        repeat (2) send_step();
        send_item(REQ_START, scoord_t'(MAX_COORD), scoord_t'(MAX_COORD),
                  scoord_t'(MAX_COORD), scoord_t'(MAX_COORD));
        send_step();
    endtask

    // Coordinate near a base, folded back when it would leave the range.
    function automatic int near_coord(input int base, input int span);
        int d;
        int v;
        d = int'($urandom_range(0, 2 * span)) - span;
        v = base + d;
        if (v > MAX_COORD || v < MIN_COORD)
            v = base - d;
        return v;
    endfunction

    // Random lines, mostly short and walked to the end, some cut or overrun.
    task automatic test_random_lines();
        int      first;
        int      kind;
        int      span;
        int      x0;
        int      y0;
        int      x1;
        int      y1;
        int      dx;
        int      dy;
        int      major;
        int      n;
        int      r;
        scoord_t seed_x;
        scoord_t seed_y;
        first = pixels_predicted;
        while (pixels_predicted - first < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                // Noise: any item type with any fields.
                send_item(logic'($urandom_range(0, 1)), scoord_t'($urandom),
                          scoord_t'($urandom), scoord_t'($urandom), scoord_t'($urandom));
            end
            else
            begin
                seed_x = scoord_t'($urandom);
                seed_y = scoord_t'($urandom);
                x0     = int'(seed_x);
                y0     = int'(seed_y);
                if (kind < 92)
                begin
                    span = (kind < 76) ? 12 : ((kind < 89) ? 40 : 300);
                    x1   = near_coord(x0, span);
                    y1   = near_coord(y0, span);
                end
                else
                begin
                    x1 = int'(scoord_t'($urandom));
                    y1 = int'(scoord_t'($urandom));
                end
                dx    = (x1 > x0) ? x1 - x0 : x0 - x1;
                dy    = (y1 > y0) ? y1 - y0 : y0 - y1;
                major = (dx > dy) ? dx : dy;
                send_item(REQ_START, scoord_t'(x0), scoord_t'(y0),
                          scoord_t'(x1), scoord_t'(y1));
                // Long lines get at most six steps; the next start cuts them off.
                if (kind >= 92)
                    n = $urandom_range(0, 6);
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 10 && major > 0)
                        n = $urandom_range(0, major - 1);
                    else if (r < 20)
                        n = major + $urandom_range(1, 3);
                    else
                        n = major;
                end
                repeat (n) send_step();
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_step();
        test_degenerate();
        test_octants();
        test_extremes();
        test_random_lines();

        req_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
            report($sformatf("%0d predicted pixels never arrived", pending_pixels.size()));

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/blr_pkg.sv
sv/bresenham_line_rasterizer.sv
sv/blr_checker.sv
test/bresenham_line_rasterizer_tb.sv
